// ===== design/pan_tilt_command_positioner_unit_assert.svh =====
// Assertion macros used by the pan/tilt positioner checker
`ifndef PAN_TILT_COMMAND_POSITIONER_UNIT_ASSERT_SVH
`define PAN_TILT_COMMAND_POSITIONER_UNIT_ASSERT_SVH

// same-cycle implication
`define PTCP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PTCP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ptcp_pkg.sv =====
// Types, constants and helper functions of the pan/tilt command positioner
`default_nettype none
package ptcp_pkg;

    typedef enum logic [2:0] {
        CMD_LEFT     = 3'd0,
        CMD_RIGHT    = 3'd1,
        CMD_UP       = 3'd2,
        CMD_DOWN     = 3'd3,
        CMD_CENTER   = 3'd4,
        CMD_DIGIT    = 3'd5,
        CMD_CLEAR    = 3'd6,
        CMD_JOYSTICK = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        CFG_PAN_LIMIT  = 2'd0,
        CFG_TILT_LIMIT = 2'd1,
        CFG_CENTER     = 2'd2,
        CFG_DEADBAND   = 2'd3
    } t_cfg_idx;

    localparam logic [9:0]        PendMax       = 10'd999;
    localparam logic [3:0]        DigitMax      = 4'd9;
    localparam logic [6:0]        PanLimitRst   = 7'd85;
    localparam logic [6:0]        TiltLimitRst  = 7'd80;
    localparam logic signed [7:0] CenterTiltRst = 8'sd55;
    localparam logic [3:0]        DeadbandRst   = 4'd2;

    typedef struct packed {
        logic [2:0]  command;
        logic        from_serial;
        logic [3:0]  digit_value;
        logic [11:0] stick_x_raw;
        logic [11:0] stick_y_raw;
    } t_in_word;

    typedef struct packed {
        logic signed [7:0] pan;
        logic signed [7:0] tilt;
        logic [9:0]        pend_val;
        logic              pend_set;
    } t_pos_state;

    typedef struct packed {
        logic [6:0]        pan_limit;
        logic [6:0]        tilt_limit;
        logic signed [7:0] center_tilt;
        logic [3:0]        deadband;
    } t_cfg;

    // trunc(raw*20/4096) == (raw*5) >> 10, range 0..19
    function automatic logic [4:0] joy_quant(input logic [11:0] raw);
        logic [14:0] prod;
        prod = 15'(raw) * 15'd5;
        return prod[14:10];
    endfunction

    function automatic logic signed [7:0] clamp_sym(input logic signed [11:0] v,
                                                    input logic [6:0] lim);
        logic signed [11:0] l;
        logic signed [11:0] r;
        l = signed'({5'b00000, lim});
        r = v;
        if (v > l) begin
            r = l;
        end else if (v < -l) begin
            r = -l;
        end
        return signed'(r[7:0]);
    endfunction

endpackage
`default_nettype wire

// ===== design/ptcp_in_stage.sv =====
// Input register stage of the pan/tilt command positioner
`default_nettype none
module ptcp_in_stage
    import ptcp_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_in_word i_word,
    output logic          o_valid,
    input  wire logic     i_take,
    output t_in_word      o_word
);

    logic     r_valid;
    t_in_word r_word;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= i_word;
        end
    end

endmodule
`default_nettype wire

// ===== design/ptcp_exec.sv =====
// Command datapath: step, center, digit entry, clear, joystick map and clamp
`default_nettype none
module ptcp_exec
    import ptcp_pkg::*;
(
    input  wire t_in_word   i_word,
    input  wire t_pos_state i_state,
    input  wire t_cfg       i_cfg,
    output t_pos_state      o_state
);

    t_cmd               w_cmd;
    logic               w_take;
    logic signed [11:0] w_step;
    logic signed [11:0] w_pan;
    logic signed [11:0] w_tilt;
    logic [9:0]         w_base;
    logic [13:0]        w_acc;
    logic [4:0]         w_qx;
    logic [4:0]         w_qy;
    logic signed [5:0]  w_jx;
    logic signed [5:0]  w_jy;
    logic [5:0]         w_ax;
    logic [5:0]         w_ay;
    logic               w_joy_move;

    assign w_cmd  = t_cmd'(i_word.command);
    assign w_take = (w_cmd == CMD_LEFT || w_cmd == CMD_RIGHT || w_cmd == CMD_UP ||
                     w_cmd == CMD_DOWN) && !i_word.from_serial && i_state.pend_set;
    assign w_step = w_take ? signed'({2'b00, i_state.pend_val}) : 12'sd1;

    assign w_base = i_state.pend_set ? i_state.pend_val : 10'd0;
    assign w_acc  = 14'(w_base) * 14'd10 + 14'(i_word.digit_value);

    assign w_qx = joy_quant(i_word.stick_x_raw);
    assign w_qy = joy_quant(i_word.stick_y_raw);
    assign w_jx = 6'sd10 - signed'({1'b0, w_qx});
    assign w_jy = signed'({1'b0, w_qy}) - 6'sd10;
    assign w_ax = (w_jx < 0) ? 6'(-w_jx) : 6'(w_jx);
    assign w_ay = (w_jy < 0) ? 6'(-w_jy) : 6'(w_jy);
    assign w_joy_move = (w_ax >= 6'(i_cfg.deadband)) || (w_ay >= 6'(i_cfg.deadband));

    always_comb begin
        w_pan            = 12'(i_state.pan);
        w_tilt           = 12'(i_state.tilt);
        o_state.pend_val = i_state.pend_val;
        o_state.pend_set = i_state.pend_set;
        case (w_cmd)
            CMD_LEFT:   w_pan  = w_pan + w_step;
            CMD_RIGHT:  w_pan  = w_pan - w_step;
            CMD_UP:     w_tilt = w_tilt - w_step;
            CMD_DOWN:   w_tilt = w_tilt + w_step;
            CMD_CENTER: begin
                w_pan  = 12'sd0;
                w_tilt = 12'(i_cfg.center_tilt);
            end
            CMD_DIGIT: begin
                if (i_word.digit_value <= DigitMax) begin
                    o_state.pend_val = (w_acc > 14'(PendMax)) ? PendMax : w_acc[9:0];
                    o_state.pend_set = 1'b1;
                end
            end
            CMD_CLEAR: begin
                o_state.pend_val = 10'd0;
                o_state.pend_set = 1'b0;
            end
            CMD_JOYSTICK: begin
                if (w_joy_move) begin
                    w_pan  = w_pan + 12'(w_jx);
                    w_tilt = w_tilt - 12'(w_jy);
                end
            end
            default: begin
            end
        endcase
        if (w_take) begin
            o_state.pend_val = 10'd0;
            o_state.pend_set = 1'b0;
        end
        o_state.pan  = clamp_sym(w_pan, i_cfg.pan_limit);
        o_state.tilt = clamp_sym(w_tilt, i_cfg.tilt_limit);
    end

endmodule
`default_nettype wire

// ===== design/pan_tilt_command_positioner_unit.sv =====
// Top level of the pan/tilt command positioner
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+------------------------------------
//   in      | input     | i_in_valid / o_in_ready  | command, serial flag, digit, stick x/y
//   out     | output    | o_out_valid / i_out_ready| pan, tilt, pending angle, pending set
//   cfg     | input     | i_cfg_we                 | i_cfg_index, i_cfg_data
//
// One word per cycle unless the output stalls; each accepted word waits in the input
// register, and its result is registered into the result register. The rate is set by the
// combinational datapath to the position/result registers, which update together.
// Synchronous active-low reset clears positions and holds a pending angle of zero.
// A stalled output holds its result; the input register fills behind it, then ready drops.
`default_nettype none
module pan_tilt_command_positioner_unit
    import ptcp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [2:0]        i_command,
    input  wire logic              i_from_serial,
    input  wire logic [3:0]        i_digit_value,
    input  wire logic [11:0]       i_stick_x_raw,
    input  wire logic [11:0]       i_stick_y_raw,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic signed [7:0]      o_pan_angle,
    output logic signed [7:0]      o_tilt_angle,
    output logic [9:0]             o_pending_angle,
    output logic                   o_pending_set,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic [7:0]        i_cfg_data
);

    t_in_word   w_in_word;
    t_in_word   w_stage_word;
    logic       w_stage_valid;
    logic       w_fire;
    t_pos_state r_state;
    t_pos_state n_state;
    t_pos_state r_out;
    logic       r_out_valid;
    t_cfg       r_cfg;

    assign w_in_word = '{command:     i_command,
                         from_serial: i_from_serial,
                         digit_value: i_digit_value,
                         stick_x_raw: i_stick_x_raw,
                         stick_y_raw: i_stick_y_raw};

    assign w_fire = w_stage_valid && (!r_out_valid || i_out_ready);

    ptcp_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_word  (w_in_word),
        .o_valid (w_stage_valid),
        .i_take  (w_fire),
        .o_word  (w_stage_word)
    );

    ptcp_exec u_exec (
        .i_word  (w_stage_word),
        .i_state (r_state),
        .i_cfg   (r_cfg),
        .o_state (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pan_limit   <= PanLimitRst;
            r_cfg.tilt_limit  <= TiltLimitRst;
            r_cfg.center_tilt <= CenterTiltRst;
            r_cfg.deadband    <= DeadbandRst;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PAN_LIMIT:  r_cfg.pan_limit   <= i_cfg_data[6:0];
                CFG_TILT_LIMIT: r_cfg.tilt_limit  <= i_cfg_data[6:0];
                CFG_CENTER:     r_cfg.center_tilt <= signed'(i_cfg_data);
                CFG_DEADBAND:   r_cfg.deadband    <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{pan: 8'sd0, tilt: 8'sd0, pend_val: 10'd0, pend_set: 1'b1};
        end else if (w_fire) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= n_state;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_pan_angle     = r_out.pan;
    assign o_tilt_angle    = r_out.tilt;
    assign o_pending_angle = r_out.pend_val;
    assign o_pending_set   = r_out.pend_set;

endmodule
`default_nettype wire

// ===== design/ptcp_checker.sv =====
// Port-level checker for the pan/tilt command positioner and its bind
`default_nettype none
`include "pan_tilt_command_positioner_unit_assert.svh"
module ptcp_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_out_valid,
    input wire logic              i_out_ready,
    input wire logic signed [7:0] o_pan_angle,
    input wire logic signed [7:0] o_tilt_angle,
    input wire logic [9:0]        o_pending_angle,
    input wire logic              o_pending_set
);

    `PTCP_ASSERT_NOW(a_clear_reads_zero, i_clk, i_rst_n, o_out_valid && !o_pending_set, o_pending_angle == 10'd0, "pending angle nonzero while none held")

    `PTCP_ASSERT_NOW(a_pending_sat, i_clk, i_rst_n, o_out_valid, o_pending_angle <= 10'd999, "pending angle above saturation")

    `PTCP_ASSERT_NOW(a_clamp_sym, i_clk, i_rst_n, o_out_valid, (o_pan_angle != -8'sd128) && (o_tilt_angle != -8'sd128), "angle outside symmetric clamp")

    `PTCP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_pan_angle) && $stable(o_tilt_angle) && $stable(o_pending_angle) && $stable(o_pending_set), "stalled result changed")

endmodule

bind pan_tilt_command_positioner_unit ptcp_checker u_ptcp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_pan_angle     (o_pan_angle),
    .o_tilt_angle    (o_tilt_angle),
    .o_pending_angle (o_pending_angle),
    .o_pending_set   (o_pending_set)
);
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench of the pan/tilt command positioner: predicted results, random traffic
module tb
    import ptcp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    class pos_scoreboard;
        int pan_lim;
        int tilt_lim;
        int center;
        int deadband;
        int pan;
        int tilt;
        int pend_val;
        bit pend_set;
        t_pos_state expected_q[$];
        int errors;

        function new();
            pan_lim  = int'(PanLimitRst);
            tilt_lim = int'(TiltLimitRst);
            center   = int'(CenterTiltRst);
            deadband = int'(DeadbandRst);
            pan      = 0;
            tilt     = 0;
            pend_val = 0;
            pend_set = 1'b1;
            errors   = 0;
        endfunction

        function void write_cfg(t_cfg_idx idx, logic [7:0] data);
            case (idx)
                CFG_PAN_LIMIT:  pan_lim  = int'(data[6:0]);
                CFG_TILT_LIMIT: tilt_lim = int'(data[6:0]);
                CFG_CENTER:     center   = int'($signed(data));
                CFG_DEADBAND:   deadband = int'(data[3:0]);
                default: ;
            endcase
        endfunction

        function int step_size(bit serial);
            int s;
            s = 1;
            if (!serial && pend_set) begin
                s        = pend_val;
                pend_set = 1'b0;
                pend_val = 0;
            end
            return s;
        endfunction

        function int clamp(int v, int l);
            if (v > l) begin
                return l;
            end else if (v < -l) begin
                return -l;
            end
            return v;
        endfunction

        function void note_input(t_in_word w);
            t_pos_state e;
            int x;
            int y;
            int v;
            case (t_cmd'(w.command))
                CMD_LEFT:   pan  = pan + step_size(w.from_serial);
                CMD_RIGHT:  pan  = pan - step_size(w.from_serial);
                CMD_UP:     tilt = tilt - step_size(w.from_serial);
                CMD_DOWN:   tilt = tilt + step_size(w.from_serial);
                CMD_CENTER: begin
                    pan  = 0;
                    tilt = center;
                end
                CMD_DIGIT: begin
                    if (w.digit_value <= DigitMax) begin
                        v = pend_set ? pend_val : 0;
                        v = v * 10 + int'(w.digit_value);
                        if (v > int'(PendMax)) begin
                            v = int'(PendMax);
                        end
                        pend_val = v;
                        pend_set = 1'b1;
                    end
                end
                CMD_CLEAR: begin
                    pend_set = 1'b0;
                    pend_val = 0;
                end
                default: begin
                    x = 10 - (int'(w.stick_x_raw) * 20) / 4096;
                    y = (int'(w.stick_y_raw) * 20) / 4096 - 10;
                    if ((x < 0 ? -x : x) >= deadband || (y < 0 ? -y : y) >= deadband) begin
                        pan  = pan + x;
                        tilt = tilt - y;
                    end
                end
            endcase
            pan  = clamp(pan, pan_lim);
            tilt = clamp(tilt, tilt_lim);
            e.pan      = pan[7:0];
            e.tilt     = tilt[7:0];
            e.pend_val = pend_val[9:0];
            e.pend_set = pend_set;
            expected_q.push_back(e);
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(t_pos_state got);
            t_pos_state e;
            if (expected_q.size() == 0) begin
                report("result word with nothing expected");
            end else begin
                e = expected_q.pop_front();
                if (got.pan !== e.pan) begin
                    report($sformatf("pan got %0d want %0d", got.pan, e.pan));
                end
                if (got.tilt !== e.tilt) begin
                    report($sformatf("tilt got %0d want %0d", got.tilt, e.tilt));
                end
                if (got.pend_val !== e.pend_val) begin
                    report($sformatf("pending angle got %0d want %0d", got.pend_val, e.pend_val));
                end
                if (got.pend_set !== e.pend_set) begin
                    report($sformatf("pending set got %0b want %0b", got.pend_set, e.pend_set));
                end
            end
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        o_in_ready;
    logic [2:0]  in_command = '0;
    logic        in_from_serial = 1'b0;
    logic [3:0]  in_digit = '0;
    logic [11:0] in_stick_x = '0;
    logic [11:0] in_stick_y = '0;
    logic        o_out_valid;
    logic        out_ready = 1'b0;
    logic signed [7:0] o_pan_angle;
    logic signed [7:0] o_tilt_angle;
    logic [9:0]  o_pending_angle;
    logic        o_pending_set;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;

    bit no_idle = 1'b0;
    bit rx_long_hold = 1'b0;
    pos_scoreboard sb = new();

    pan_tilt_command_positioner_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (o_in_ready),
        .i_command       (in_command),
        .i_from_serial   (in_from_serial),
        .i_digit_value   (in_digit),
        .i_stick_x_raw   (in_stick_x),
        .i_stick_y_raw   (in_stick_y),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .o_pan_angle     (o_pan_angle),
        .o_tilt_angle    (o_tilt_angle),
        .o_pending_angle (o_pending_angle),
        .o_pending_set   (o_pending_set),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("tb: errors");
        $finish;
    end

    function int draw_gap();
        if (no_idle || $urandom_range(0, 3) == 0) begin
            return 0;
        end
        return $urandom_range(0, 18);
    endfunction

    function t_in_word mk(t_cmd c, bit serial, logic [3:0] digit, logic [11:0] x,
                          logic [11:0] y);
        t_in_word w;
        w.command     = c;
        w.from_serial = serial;
        w.digit_value = digit;
        w.stick_x_raw = x;
        w.stick_y_raw = y;
        return w;
    endfunction

    function logic [11:0] rand_raw();
        case ($urandom_range(0, 5))
            0:       return 12'd0;
            1:       return 12'd4095;
            2:       return 12'($urandom_range(1843, 2252));
            default: return 12'($urandom_range(0, 4095));
        endcase
    endfunction

    function t_in_word rand_word(t_cmd c, bit serial, logic [3:0] digit);
        return mk(c, serial, digit, rand_raw(), rand_raw());
    endfunction

    task send_word(t_in_word w);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_command     = w.command;
        in_from_serial = w.from_serial;
        in_digit       = w.digit_value;
        in_stick_x     = w.stick_x_raw;
        in_stick_y     = w.stick_y_raw;
        in_valid       = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(w);
        @(negedge i_clk);
    endtask

    // well-formed remote step entry in four groups of ten, the rest loose commands
    task send_group(inout int sent);
        int k;
        t_cmd mv;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                k = $urandom_range(1, 3);
                repeat (k) begin
                    send_word(rand_word(CMD_DIGIT, $urandom_range(0, 1),
                                        4'($urandom_range(0, 9))));
                end
                if ($urandom_range(0, 3) == 0) begin
                    send_word(rand_word(t_cmd'($urandom_range(CMD_LEFT, CMD_DOWN)), 1'b1,
                                        4'($urandom_range(0, 15))));
                    sent++;
                end
                mv = t_cmd'($urandom_range(CMD_LEFT, CMD_DOWN));
                send_word(rand_word(mv, 1'b0, 4'($urandom_range(0, 15))));
                sent += k + 1;
            end
            4, 5: begin
                send_word(rand_word(CMD_JOYSTICK, $urandom_range(0, 1),
                                    4'($urandom_range(0, 15))));
                sent++;
            end
            6: begin
                send_word(rand_word(CMD_CENTER, $urandom_range(0, 1), 4'($urandom_range(0, 15))));
                sent++;
            end
            7: begin
                send_word(rand_word(CMD_CLEAR, $urandom_range(0, 1), 4'($urandom_range(0, 15))));
                sent++;
            end
            8: begin
                send_word(rand_word(t_cmd'($urandom_range(CMD_LEFT, CMD_DOWN)),
                                    $urandom_range(0, 1), 4'($urandom_range(0, 15))));
                sent++;
            end
            default: begin
                send_word(rand_word(t_cmd'($urandom_range(CMD_LEFT, CMD_JOYSTICK)),
                                    $urandom_range(0, 1), 4'($urandom_range(0, 15))));
                sent++;
            end
        endcase
    endtask

    task wait_drained();
        in_valid = 1'b0;
        while (sb.expected_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task write_config(logic [6:0] pan_lim, logic [6:0] tilt_lim, logic [7:0] center,
                      logic [3:0] db);
        logic [7:0] vals[4];
        vals[0] = {1'($urandom_range(0, 1)), pan_lim};
        vals[1] = {1'($urandom_range(0, 1)), tilt_lim};
        vals[2] = center;
        vals[3] = {4'($urandom_range(0, 15)), db};
        cfg_we = 1'b1;
        for (int i = 0; i < 4; i++) begin
            cfg_index = t_cfg_idx'(i);
            cfg_data  = vals[i];
            sb.write_cfg(t_cfg_idx'(i), vals[i]);
            @(negedge i_clk);
        end
        cfg_we = 1'b0;
    endtask

    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            if (rx_long_hold) begin
                out_ready = 1'b0;
                repeat (120) @(negedge i_clk);
                rx_long_hold = 1'b0;
            end
            gap = draw_gap();
            if (gap > 0) begin
                out_ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_ready = 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            sb.check_result({o_pan_angle, o_tilt_angle, o_pending_angle, o_pending_set});
            @(negedge i_clk);
        end
    end

    initial begin
        int sent;
        int target;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        send_word(mk(CMD_LEFT, 1'b0, 4'd0, 12'd0, 12'd0));
        send_word(mk(CMD_RIGHT, 1'b0, 4'd0, 12'd0, 12'd0));
        send_word(mk(CMD_UP, 1'b0, 4'd0, 12'd0, 12'd0));
        send_word(mk(CMD_DOWN, 1'b1, 4'd0, 12'd0, 12'd0));
        send_word(mk(CMD_DIGIT, 1'b0, 4'd9, 12'd0, 12'd0));
        send_word(mk(CMD_DIGIT, 1'b1, 4'd9, 12'd0, 12'd0));
        send_word(mk(CMD_DIGIT, 1'b0, 4'd9, 12'd0, 12'd0));
        send_word(mk(CMD_DIGIT, 1'b0, 4'd9, 12'd0, 12'd0));
        send_word(mk(CMD_LEFT, 1'b0, 4'd0, 12'd0, 12'd0));
        send_word(mk(CMD_DIGIT, 1'b0, 4'd15, 12'd0, 12'd0));
        send_word(mk(CMD_DIGIT, 1'b0, 4'd7, 12'd0, 12'd0));
        send_word(mk(CMD_DOWN, 1'b1, 4'd0, 12'd0, 12'd0));
        send_word(mk(CMD_UP, 1'b0, 4'd0, 12'd0, 12'd0));
        send_word(mk(CMD_DIGIT, 1'b0, 4'd3, 12'd0, 12'd0));
        send_word(mk(CMD_CLEAR, 1'b1, 4'd0, 12'd0, 12'd0));
        send_word(mk(CMD_LEFT, 1'b0, 4'd0, 12'd0, 12'd0));
        send_word(mk(CMD_CENTER, 1'b1, 4'd0, 12'd0, 12'd0));
        send_word(mk(CMD_JOYSTICK, 1'b0, 4'd0, 12'd0, 12'd4095));
        send_word(mk(CMD_JOYSTICK, 1'b0, 4'd0, 12'd4095, 12'd0));
        send_word(mk(CMD_JOYSTICK, 1'b0, 4'd0, 12'd2048, 12'd2048));
        send_word(mk(CMD_JOYSTICK, 1'b0, 4'd0, 12'd2457, 12'd1639));
        send_word(mk(CMD_JOYSTICK, 1'b1, 4'd15, 12'd4095, 12'd4095));
        send_word(mk(CMD_RIGHT, 1'b0, 4'd15, 12'd4095, 12'd4095));

        for (int p = 0; p < 8; p++) begin
            wait_drained();
            case (p)
                0: write_config(7'd127, 7'd127, 8'h7F, 4'd0);
                1: write_config(7'd0, 7'd0, 8'h80, 4'd15);
                2: write_config(7'd90, 7'd90, -8'sd90, 4'd10);
                3: write_config(7'd90, 7'd90, 8'sd90, 4'd1);
                4: write_config(PanLimitRst, TiltLimitRst, CenterTiltRst, DeadbandRst);
                default: write_config(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                                      8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
            endcase
            no_idle = (p == 3 || p == 5);
            if (p == 5) begin
                rx_long_hold = 1'b1;
            end
            sent = 0;
            target = 235;
            while (sent < target) begin
                send_group(sent);
            end
            no_idle = 1'b0;
        end

        wait_drained();
        repeat (30) @(negedge i_clk);
        if (sb.expected_q.size() != 0) begin
            sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));
        end
        if (sb.errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end
endmodule
